// ===== src/slie_pkg.sv =====
// Shared types and constants for the sorted list insert engine.
// Used by slie_cell, sorted_list_insert_engine and the testbench; no other dependencies.
`timescale 1ns / 1ps
`default_nettype none
package slie_pkg;

	// List geometry
	localparam int LIST_DEPTH = 16;
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

	// Command codes
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_PUSH   = 2'd1;
	localparam logic [1:0] CMD_POP    = 2'd2;

	// Front value reported for an empty list
	localparam logic signed [31:0] EMPTY_FRONT = -32'sd1;

	typedef logic signed [31:0] data_t;

	// Per-cycle control broadcast to every cell
	typedef struct packed {
		logic   ins_en;   // insert or push that is taken
		logic   pop_en;   // pop that is taken
		data_t  new_val;  // value being placed
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== src/slie_cell.sv =====
// One slot of the ordered list: holds a value, finds its own insert
// decision from a ripple flag and shifts with its neighbors. Uses slie_pkg.
`timescale 1ns / 1ps
`default_nettype none
module slie_cell (
	input  wire                  clk,
	input  slie_pkg::cell_ctl_t  ctl,
	input  wire                  occupied,   // slot lies below the entry count
	input  wire                  force_hit,  // push front: slot 0 takes the value
	input  wire                  found_in,   // insert point lies in an earlier slot
	input  slie_pkg::data_t      left_val,   // value of the slot in front
	input  slie_pkg::data_t      right_val,  // value of the slot behind
	output logic                 found_out,
	output slie_pkg::data_t      val
);

	slie_pkg::data_t val_q;
	logic            hit;

	// First slot that is free or holds a greater value takes the new entry; a push forces slot 0
	assign hit       = force_hit || !occupied || (val_q > ctl.new_val);
	assign found_out = found_in || hit;
	assign val       = val_q;

	// Slot storage: shift back behind the insert point, forward on pop
	always_ff @(posedge clk) begin
		if (ctl.ins_en) begin
			if (found_in) begin
				val_q <= left_val;
			end else if (hit) begin
				val_q <= ctl.new_val;
			end
		end else if (ctl.pop_en) begin
			val_q <= right_val;
		end
	end

endmodule
`default_nettype wire

// ===== src/sorted_list_insert_engine.sv =====
// Top level of the sorted list insert engine: command decode, entry count,
// the row of slie_cell slots and the result register. Uses slie_pkg.
//
//  channel   handshake          fields
//  command   start & !busy      cmd, value
//  result    done (1 cycle)     front_value, list_empty, entry_count, dropped
//
// One command per cycle; busy stays low. The result appears in the cycle after
// the transfer, for that cycle only. The insert point is found in the same
// cycle by a flag that ripples through the row of cells.
// Reset clears the entry count, the result strobe and the dropped flag; slot
// contents are only read below the entry count. The receiver cannot stall results.
`timescale 1ns / 1ps
`default_nettype none
module sorted_list_insert_engine (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        start,
	output logic                       busy,
	input  wire  [1:0]                 cmd,
	input  wire  signed [31:0]         value,
	output logic                       done,
	output logic signed [31:0]         front_value,
	output logic                       list_empty,
	output logic [slie_pkg::CNT_W-1:0] entry_count,
	output logic                       dropped
);

	localparam int D = slie_pkg::LIST_DEPTH;

	logic [slie_pkg::CNT_W-1:0] count_q;
	logic                       done_q;
	logic                       dropped_q;
	logic                       xfer;
	logic                       full;
	logic                       is_ins;
	logic                       is_pop;
	logic                       drop;
	slie_pkg::cell_ctl_t        ctl;
	logic [D:0]                 found;
	slie_pkg::data_t            vals [D];

	assign busy = 1'b0;
	assign xfer = start && !busy;
	assign full = (count_q == slie_pkg::CNT_W'(D));

	// Command decode
	always_comb begin
		is_ins = 1'b0;
		is_pop = 1'b0;
		unique case (cmd) inside
			slie_pkg::CMD_INSERT, slie_pkg::CMD_PUSH: is_ins = 1'b1;
			slie_pkg::CMD_POP:                        is_pop = 1'b1;
			default:                                  ;
		endcase
	end

	assign drop = (is_ins && full) || (is_pop && count_q == '0);

	assign ctl.ins_en  = xfer && is_ins && !full;
	assign ctl.pop_en  = xfer && is_pop && count_q != '0;
	assign ctl.new_val = value;

	// Row of slots
	assign found[0] = 1'b0;
	for (genvar i = 0; i < D; i++) begin : g_cell
		slie_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (slie_pkg::CNT_W'(i) < count_q),
			.force_hit ((i == 0) && (cmd == slie_pkg::CMD_PUSH)),
			.found_in  (found[i]),
			.left_val  ((i == 0) ? value : vals[(i == 0) ? 0 : i - 1]),
			.right_val ((i == D - 1) ? vals[i] : vals[(i == D - 1) ? i : i + 1]),
			.found_out (found[i+1]),
			.val       (vals[i])
		);
	end

	// Entry count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			done_q    <= 1'b0;
			dropped_q <= 1'b0;
		end else begin
			done_q <= xfer;
			if (xfer) begin
				dropped_q <= drop;
			end
			if (ctl.ins_en) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Result ports read the state left by the last transfer
	assign done        = done_q;
	assign list_empty  = (count_q == '0);
	assign front_value = list_empty ? slie_pkg::EMPTY_FRONT : vals[0];
	assign entry_count = count_q;
	assign dropped     = dropped_q;

`ifndef SYNTH
	// Count never passes the list depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= slie_pkg::CNT_W'(D))
		else $error("entry count above depth");

	// Every transfer gives one result in the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		xfer |=> done)
		else $error("missing result strobe");

	// A dropped command leaves the count alone
	a_drop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(xfer && drop) |=> $stable(count_q))
		else $error("dropped command changed the count");

	// A taken insert always finds a slot in the row
	a_slot_found: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.ins_en |-> found[D])
		else $error("insert found no slot");
`endif

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for sorted_list_insert_engine: directed and random commands.
// Predicts each result with its own slot array and compares every strobed result.
// Depends on slie_pkg and the sorted_list_insert_engine RTL.
`timescale 1ns / 1ps
module tb;
	import slie_pkg::*;

	localparam int RANDOM_ITEMS = 750;
	localparam int CYCLE_LIMIT  = 200000;

	typedef struct packed {
		data_t            front;
		logic             empty;
		logic [CNT_W-1:0] count;
		logic             drop;
	} list_result_t;

	logic             clk    = 1'b0;
	logic             arst_n = 1'b0;
	logic             start  = 1'b0;
	logic [1:0]       cmd    = CMD_INSERT;
	data_t            value  = '0;
	logic             busy;
	logic             done;
	data_t            front_value;
	logic             list_empty;
	logic [CNT_W-1:0] entry_count;
	logic             dropped;

	// Shadow copy of the list and the results still owed by the block
	data_t        shadow_slots [LIST_DEPTH];
	int           shadow_len = 0;
	list_result_t pending_results [$];
	int           fail_count  = 0;
	int           cycle_count = 0;
	int           burst_left  = 0;

	sorted_list_insert_engine u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.value       (value),
		.done        (done),
		.front_value (front_value),
		.list_empty  (list_empty),
		.entry_count (entry_count),
		.dropped     (dropped)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("sorted_list_insert_engine verification failed");
			$finish;
		end
	end

	// Apply one accepted command to the shadow list and queue its result
	task automatic predict_list_op(input logic [1:0] op, input data_t v);
		list_result_t r;
		int pos;
		logic drop;
		drop = 1'b0;
		case (op) inside
			CMD_INSERT, CMD_PUSH: begin
				if (shadow_len >= LIST_DEPTH) begin
					drop = 1'b1;
				end else begin
					pos = (op == CMD_PUSH) ? 0 : shadow_len;
					if (op == CMD_INSERT) begin
						// first entry strictly greater; equal entries stay ahead
						for (int i = 0; i < shadow_len; i++) begin
							if (shadow_slots[i] > v) begin
								pos = i;
								break;
							end
						end
					end
					for (int i = shadow_len; i > pos; i--)
						shadow_slots[i] = shadow_slots[i - 1];
					shadow_slots[pos] = v;
					shadow_len++;
				end
			end
			CMD_POP: begin
				if (shadow_len == 0) begin
					drop = 1'b1;
				end else begin
					for (int i = 1; i < shadow_len; i++)
						shadow_slots[i - 1] = shadow_slots[i];
					shadow_len--;
				end
			end
			default: ; // unused code: list untouched
		endcase
		r.front = (shadow_len == 0) ? EMPTY_FRONT : shadow_slots[0];
		r.empty = (shadow_len == 0);
		r.count = shadow_len[CNT_W-1:0];
		r.drop  = drop;
		pending_results.push_back(r);
	endtask

	// One command transfer; idle gaps of random length may fall between bursts
	task automatic send_cmd(input logic [1:0] op, input data_t v);
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 8);
			if ($urandom_range(0, 1) == 1) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		cmd   <= op;
		value <= v;
		do @(posedge clk); while (busy);
		predict_list_op(op, v);
	endtask

	// Result checker: one expectation per strobe
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("unexpected result: front_value %0d entry_count %0d",
					front_value, entry_count);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (front_value !== want.front) begin
					$error("front_value: expected %0d, got %0d", want.front, front_value);
					fail_count++;
				end
				if (list_empty !== want.empty) begin
					$error("list_empty: expected %0d, got %0d", want.empty, list_empty);
					fail_count++;
				end
				if (entry_count !== want.count) begin
					$error("entry_count: expected %0d, got %0d", want.count, entry_count);
					fail_count++;
				end
				if (dropped !== want.drop) begin
					$error("dropped: expected %0d, got %0d", want.drop, dropped);
					fail_count++;
				end
			end
		end
	end

	// Value source: full range, small spread, extremes, or a copy of a stored entry
	function automatic data_t pick_value();
		case ($urandom_range(0, 3))
			0: return data_t'($urandom);
			1: return data_t'($urandom_range(0, 8)) - 4;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'sh7fff_ffff;
					1: return 32'sh8000_0000;
					2: return -32'sd1;
					default: return 32'sd0;
				endcase
			end
			default: begin
				if (shadow_len == 0)
					return data_t'($urandom);
				return shadow_slots[$urandom_range(0, shadow_len - 1)];
			end
		endcase
	endfunction

	// Pop and unused code on an empty list, push onto an empty list
	task automatic test_empty_list();
		send_cmd(CMD_POP, 32'sd0);
		send_cmd(2'd3, 32'sd9);
		send_cmd(CMD_PUSH, -32'sd1); // stored -1 must not look empty
		send_cmd(CMD_POP, 32'sd0);
		send_cmd(CMD_POP, -32'sd1);
	endtask

	// Extreme values, equal entries and a push that breaks sort order
	task automatic test_ordering_extremes();
		send_cmd(CMD_INSERT, 32'sh7fff_ffff);
		send_cmd(CMD_INSERT, 32'sh8000_0000);
		send_cmd(CMD_INSERT, 32'sd0);
		send_cmd(CMD_INSERT, -32'sd1);
		send_cmd(CMD_INSERT, -32'sd1);
		send_cmd(CMD_PUSH, 32'sd7);
		send_cmd(CMD_INSERT, 32'sd3);
		send_cmd(2'd3, 32'sh5555_aaaa);
	endtask

	// Fill to capacity, then insert, push and unused code against a full list
	task automatic test_full_list();
		while (shadow_len < LIST_DEPTH)
			send_cmd(CMD_INSERT, pick_value());
		send_cmd(CMD_INSERT, 32'sd1);
		send_cmd(CMD_PUSH, 32'sh8000_0000);
		send_cmd(2'd3, 32'sd0);
	endtask

	// Phases biased toward filling, draining or a balanced mix
	task automatic test_random_mix();
		int issued;
		int phase_len;
		int kind;
		int roll;
		logic [1:0] op;
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			kind      = $urandom_range(0, 2);
			phase_len = $urandom_range(5, 40);
			repeat (phase_len) begin
				roll = $urandom_range(0, 99);
				if (roll < 4)
					op = 2'd3;
				else if (kind == 0)
					op = (roll < 60) ? CMD_INSERT : (roll < 85) ? CMD_PUSH : CMD_POP;
				else if (kind == 1)
					op = (roll < 15) ? CMD_INSERT : (roll < 25) ? CMD_PUSH : CMD_POP;
				else
					op = (roll < 40) ? CMD_INSERT : (roll < 60) ? CMD_PUSH : CMD_POP;
				send_cmd(op, pick_value());
				if (op != 2'd3)
					issued++;
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_ordering_extremes();
		test_full_list();
		test_random_mix();
		start <= 1'b0;

		// drain outstanding results, then allow for a stray strobe
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		if (fail_count == 0)
			$display("sorted_list_insert_engine verification clean");
		else
			$display("sorted_list_insert_engine verification failed");
		$finish;
	end

endmodule
